>>> hw/rtl/rru_pkg.sv
// rru_pkg: word types, fixed-point format and pipeline depth constants
// for the ray reflect/refract unit. No dependencies.
package rru_pkg;

  localparam int FRAC_BITS = 12;
  localparam int CW        = 16;            // component width
  localparam int SQ_STAGES = 16;            // two root bits per stage
  localparam int SQ_BASE   = 9;             // stage that holds the radicand
  localparam int LAST      = SQ_BASE + SQ_STAGES + 1;  // last carry stage

  localparam logic MODE_REFLECT = 1'b0;
  localparam logic MODE_REFRACT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] inc_x;
    logic signed [15:0] inc_y;
    logic signed [15:0] inc_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic        [15:0] eta;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } out_word_t;

  // Side data that travels with each word down the pipeline
  typedef struct packed {
    logic             mode;
    logic [2:0][15:0] a;
    logic [2:0][15:0] n;
    logic [15:0]      eta;
    logic [2:0][29:0] rfl;
    logic [2:0][31:0] perp;
  } car_t;

endpackage

>>> hw/rtl/ray_reflect_refract_unit.sv
// ray_reflect_refract_unit: pipelined reflect / Snell refract of a Q4.12
// direction about a surface normal. Depends on rru_pkg.
//
//  channel | ports                       | handshake
//  --------+-----------------------------+-------------------------------
//  input   | start, busy, in_word        | word taken when start && !busy
//  result  | out_strobe, out_word        | word valid for one cycle only
//
// One word enters per cycle; busy is always low. The latency is set
// by the dot product, the refract chain and the 16-stage square root
// (two root bits per stage). Reset (rst_n, synchronous) clears the valid
// bits only. The receiver cannot stall, so the pipeline never holds.
module ray_reflect_refract_unit
  import rru_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  localparam int F = FRAC_BITS;

  // Valid bits and side data, one entry per stage
  logic [LAST:1] vld_r;
  car_t          car_r [1:LAST];

  logic signed [31:0] prod_r [3];
  logic signed [33:0] d_r;
  logic signed [50:0] rp_r [3];
  logic signed [23:0] c_r;
  logic signed [39:0] cn_r [3];
  logic signed [29:0] s_r  [3];
  logic signed [46:0] es_r [3];
  logic        [63:0] sq_r [3];
  logic        [63:0] sx_r [0:SQ_STAGES];
  logic        [63:0] sr_r [0:SQ_STAGES];
  logic signed [48:0] rn_r [3];
  logic               out_strobe_r;
  out_word_t          out_word_r;

  assign busy = 1'b0;

  function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
    if (v > 51'sd32767)       return 16'sh7fff;
    else if (v < -51'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  // Stage combinational terms
  logic signed [34:0] negd;
  logic signed [34:0] c_full;
  logic signed [23:0] c_nxt;
  logic signed [51:0] rp_rnd [3];
  logic signed [29:0] rfl_nxt [3];
  logic signed [40:0] cn_rnd [3];
  logic signed [47:0] es_rnd [3];
  logic signed [31:0] perp_nxt [3];
  logic        [31:0] mag [3];
  logic        [63:0] pp;
  logic        [63:0] unit;
  logic        [63:0] q_nxt;
  logic signed [49:0] rn_rnd [3];
  logic signed [50:0] rfr [3];
  out_word_t          out_word_nxt;
  car_t               car4_nxt;
  car_t               car7_nxt;

  always_comb begin
    negd   = -{d_r[33], d_r};
    c_full = (negd + (35'sd1 <<< (F - 1))) >>> F;
    c_nxt  = (c_full > (35'sd1 <<< F)) ? 24'(35'sd1 <<< F) : c_full[23:0];
    unit   = 64'd1 << (2 * F);
    pp     = sq_r[0] + sq_r[1] + sq_r[2];
    q_nxt  = (pp > unit) ? pp - unit : unit - pp;
    car4_nxt = car_r[3];
    car7_nxt = car_r[6];
    for (int i = 0; i < 3; i++) begin
      rp_rnd[i]   = ($signed({rp_r[i][50], rp_r[i]}) + (52'sd1 <<< (2 * F - 1)))
                    >>> (2 * F);
      rfl_nxt[i]  = 30'($signed(car_r[3].a[i])) - rp_rnd[i][29:0];
      cn_rnd[i]   = ($signed({cn_r[i][39], cn_r[i]}) + (41'sd1 <<< (F - 1))) >>> F;
      es_rnd[i]   = ($signed({es_r[i][46], es_r[i]}) + (48'sd1 <<< (F - 1))) >>> F;
      if (es_rnd[i] > 48'sh7fffffff)       perp_nxt[i] = 32'sh7fffffff;
      else if (es_rnd[i] < -48'sh80000000) perp_nxt[i] = 32'sh80000000;
      else                                 perp_nxt[i] = es_rnd[i][31:0];
      mag[i]      = car_r[7].perp[i][31] ? 32'(-car_r[7].perp[i]) : car_r[7].perp[i];
      rn_rnd[i]   = ($signed({rn_r[i][48], rn_r[i]}) + (50'sd1 <<< (F - 1))) >>> F;
      rfr[i]      = 51'($signed(car_r[LAST].perp[i])) - 51'(rn_rnd[i]);
      car4_nxt.rfl[i]  = rfl_nxt[i];
      car7_nxt.perp[i] = perp_nxt[i];
    end
    if (car_r[LAST].mode == MODE_REFRACT) begin
      out_word_nxt.out_x = sat16(rfr[2]);
      out_word_nxt.out_y = sat16(rfr[1]);
      out_word_nxt.out_z = sat16(rfr[0]);
    end else begin
      out_word_nxt.out_x = sat16(51'($signed(car_r[LAST].rfl[2])));
      out_word_nxt.out_y = sat16(51'($signed(car_r[LAST].rfl[1])));
      out_word_nxt.out_z = sat16(51'($signed(car_r[LAST].rfl[0])));
    end
  end

  // Valid line and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= {vld_r[LAST-1:1], start & ~busy};
      out_strobe_r <= vld_r[LAST];
    end
  end

  // Datapath; index 2 of the packed vectors holds x, 0 holds z
  always_ff @(posedge clk) begin
    car_r[1].mode <= in_word.mode;
    car_r[1].a    <= {in_word.inc_x, in_word.inc_y, in_word.inc_z};
    car_r[1].n    <= {in_word.nrm_x, in_word.nrm_y, in_word.nrm_z};
    car_r[1].eta  <= in_word.eta;
    car_r[1].rfl  <= '0;
    car_r[1].perp <= '0;
    // Advance the side data; load the reflect and tangent terms on the way
    for (int k = 2; k <= LAST; k++) begin
      if (k == 4)      car_r[k] <= car4_nxt;
      else if (k == 7) car_r[k] <= car7_nxt;
      else             car_r[k] <= car_r[k-1];
    end
    prod_r[2] <= in_word.inc_x * in_word.nrm_x;
    prod_r[1] <= in_word.inc_y * in_word.nrm_y;
    prod_r[0] <= in_word.inc_z * in_word.nrm_z;
    d_r <= 34'(prod_r[0]) + 34'(prod_r[1]) + 34'(prod_r[2]);
    c_r <= c_nxt;
    for (int i = 0; i < 3; i++) begin
      rp_r[i] <= $signed({d_r, 1'b0}) * $signed(car_r[2].n[i]);
      cn_r[i] <= c_r * $signed(car_r[3].n[i]);
      s_r[i]  <= 30'($signed(car_r[4].a[i])) + cn_rnd[i][29:0];
      es_r[i] <= $signed({1'b0, car_r[5].eta}) * s_r[i];
      sq_r[i] <= mag[i] * mag[i];
      rn_r[i] <= $signed({1'b0, sr_r[SQ_STAGES][31:0]}) * $signed(car_r[LAST-1].n[i]);
    end
    sx_r[0] <= q_nxt;
    sr_r[0] <= '0;
    out_word_r <= out_word_nxt;
  end

  // Square root: restoring, two result bits per stage
  for (genvar g = 1; g <= SQ_STAGES; g++) begin : g_sqrt
    logic [63:0] x_nxt;
    logic [63:0] r_nxt;
    always_comb begin
      logic [63:0] bitv;
      x_nxt = sx_r[g-1];
      r_nxt = sr_r[g-1];
      for (int j = 0; j < 2; j++) begin
        bitv = 64'd1 << (62 - 2 * (2 * (g - 1) + j));
        if (x_nxt >= r_nxt + bitv) begin
          x_nxt = x_nxt - (r_nxt + bitv);
          r_nxt = (r_nxt >> 1) + bitv;
        end else begin
          r_nxt = r_nxt >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      sx_r[g] <= x_nxt;
      sr_r[g] <= r_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // Fixed latency from accept to strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(LAST + 1) out_strobe)
    else $error("result strobe missing after fixed latency");

  // No strobe without a matching earlier accept
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(vld_r[1], LAST))
    else $error("result strobe without accepted word");

  // Reflect with a zero normal passes the incident direction through
  a_refl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_word.mode == MODE_REFLECT && in_word.nrm_x == 16'sd0 &&
     in_word.nrm_y == 16'sd0 && in_word.nrm_z == 16'sd0)
    |-> ##(LAST + 1) (out_word.out_x == $past(in_word.inc_x, LAST + 1) &&
                      out_word.out_y == $past(in_word.inc_y, LAST + 1) &&
                      out_word.out_z == $past(in_word.inc_z, LAST + 1)))
    else $error("reflect about zero normal changed the direction");

endmodule
